// ----- hdl/sync_code_image_deframer_top_assert.svh -----
// Assertion macros for the sync code image deframer
`ifndef SYNC_CODE_IMAGE_DEFRAMER_TOP_ASSERT_SVH
`define SYNC_CODE_IMAGE_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define SCID_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/scid_pkg.sv -----
// Package with the sync codes, limits and the result record of the deframer
package scid_pkg;

    localparam logic [7:0] SYNC_LEAD = 8'd255;
    localparam logic [7:0] CODE_SOF  = 8'd175;
    localparam logic [7:0] CODE_SOL  = 8'd128;
    localparam logic [7:0] CODE_EOL  = 8'd218;
    localparam logic [7:0] CODE_EOF  = 8'd171;

    localparam logic       KIND_PIXEL   = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;

    localparam logic [15:0] MAX_FRAME_BYTES_RESET = 16'd256;
    localparam logic [1:0]  WINDOW_FULL           = 2'd3;
    localparam logic [7:0]  COUNT_MAX             = 8'd255;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  pixel;
        logic [7:0]  frame_width;
        logic [7:0]  frame_height;
        logic [15:0] frame_bytes;
        logic        overflow;
    } result_t;

endpackage

// ----- hdl/sync_code_image_deframer_top.sv -----
// Sync code image deframer: marker detection, pixel passing and frame summary
//
// Input channel: one camera byte per transaction on byte_in (in_valid/in_stall).
// Output channel: one result per transaction; result_kind 0 carries a pixel,
// result_kind 1 is the end-of-frame summary. Width, height, byte count and
// overflow ride along with every result.
// A byte is decoded in the cycle it is taken; its result, if any, goes into the
// output register, or the skid register on a stall. One byte is taken every cycle
// while the output side keeps up, so throughput is one byte per clock.
// The three most recent bytes are held back, so a pixel leaves three input
// bytes after it entered; marker bytes never leave.
// When the receiver stalls, the pending result holds and one more result
// lands in a skid register; in_stall then rises until the skid drains.
// max_frame_bytes is written through cfg_write_en/cfg_write_data; the user must write
// it only while idle, which the block does not enforce. Reset clears the window, all
// counters and flags, empties both output registers and loads max_frame_bytes with 256.
module sync_code_image_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [7:0]  pixel,
    output logic [7:0]  frame_width,
    output logic [7:0]  frame_height,
    output logic [15:0] frame_bytes,
    output logic        overflow
);

`include "sync_code_image_deframer_top_assert.svh"

    logic [15:0] max_frame_bytes_reg;
    logic [7:0]  win0_reg, win1_reg, win2_reg;
    logic [7:0]  win0_next, win1_next, win2_next;
    logic [1:0]  fill_reg, fill_next;
    logic        in_frame_reg, in_frame_next;
    logic        in_line_reg, in_line_next;
    logic [7:0]  line_count_reg, line_count_next;
    logic [7:0]  last_width_reg, last_width_next;
    logic [7:0]  line_total_reg, line_total_next;
    logic [15:0] byte_total_reg, byte_total_next;
    logic        drop_reg, drop_next;

    scid_pkg::result_t out_reg, skid_reg, res_next;
    logic              out_valid_reg, skid_valid_reg, res_valid;

    logic in_acc, out_take, win_full, is_marker;

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;
    assign win_full = (fill_reg == scid_pkg::WINDOW_FULL);
    assign is_marker = win_full && (win0_reg == scid_pkg::SYNC_LEAD)
                       && (win1_reg == 8'd0) && (win2_reg == 8'd0)
                       && ((byte_in == scid_pkg::CODE_SOF) || (byte_in == scid_pkg::CODE_SOL)
                           || (byte_in == scid_pkg::CODE_EOL)
                           || (byte_in == scid_pkg::CODE_EOF));

    always_comb
    begin
        win0_next        = win0_reg;
        win1_next        = win1_reg;
        win2_next        = win2_reg;
        fill_next        = fill_reg;
        in_frame_next    = in_frame_reg;
        in_line_next     = in_line_reg;
        line_count_next  = line_count_reg;
        last_width_next  = last_width_reg;
        line_total_next  = line_total_reg;
        byte_total_next  = byte_total_reg;
        drop_next        = drop_reg;
        res_valid        = 1'b0;
        res_next.result_kind  = scid_pkg::KIND_PIXEL;
        res_next.pixel        = 8'd0;
        res_next.frame_width  = last_width_reg;
        res_next.frame_height = line_total_reg;
        res_next.frame_bytes  = byte_total_reg;
        res_next.overflow     = drop_reg;

        if (is_marker)
        begin
            win0_next = 8'd0;
            win1_next = 8'd0;
            win2_next = 8'd0;
            fill_next = 2'd0;
            if (byte_in == scid_pkg::CODE_SOF)
            begin
                in_frame_next   = 1'b1;
                in_line_next    = 1'b0;
                line_count_next = 8'd0;
                last_width_next = 8'd0;
                line_total_next = 8'd0;
                byte_total_next = 16'd0;
                drop_next       = 1'b0;
            end
            else if (in_frame_reg)
            begin
                priority if (byte_in == scid_pkg::CODE_SOL)
                begin
                    in_line_next    = 1'b1;
                    line_count_next = 8'd0;
                end
                else if (byte_in == scid_pkg::CODE_EOL)
                begin
                    last_width_next = line_count_reg;
                    if (line_total_reg != scid_pkg::COUNT_MAX)
                        line_total_next = line_total_reg + 8'd1;
                    in_line_next = 1'b0;
                end
                else
                begin
                    res_valid            = 1'b1;
                    res_next.result_kind = scid_pkg::KIND_SUMMARY;
                    in_frame_next        = 1'b0;
                    in_line_next         = 1'b0;
                end
            end
        end
        else if (win_full)
        begin
            win0_next = win1_reg;
            win1_next = win2_reg;
            win2_next = byte_in;
            if (in_frame_reg && in_line_reg)
            begin
                if (line_count_reg != scid_pkg::COUNT_MAX)
                    line_count_next = line_count_reg + 8'd1;
                if (byte_total_reg < max_frame_bytes_reg)
                begin
                    byte_total_next      = byte_total_reg + 16'd1;
                    res_valid            = 1'b1;
                    res_next.pixel       = win0_reg;
                    res_next.frame_bytes = byte_total_reg + 16'd1;
                end
                else
                begin
                    drop_next = 1'b1;
                end
            end
        end
        else
        begin
            unique case (fill_reg)
                2'd0:    win0_next = byte_in;
                2'd1:    win1_next = byte_in;
                default: win2_next = byte_in;
            endcase
            fill_next = fill_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_bytes_reg <= scid_pkg::MAX_FRAME_BYTES_RESET;
            win0_reg       <= 8'd0;
            win1_reg       <= 8'd0;
            win2_reg       <= 8'd0;
            fill_reg       <= 2'd0;
            in_frame_reg   <= 1'b0;
            in_line_reg    <= 1'b0;
            line_count_reg <= 8'd0;
            last_width_reg <= 8'd0;
            line_total_reg <= 8'd0;
            byte_total_reg <= 16'd0;
            drop_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                max_frame_bytes_reg <= cfg_write_data;
            if (in_acc)
            begin
                win0_reg       <= win0_next;
                win1_reg       <= win1_next;
                win2_reg       <= win2_next;
                fill_reg       <= fill_next;
                in_frame_reg   <= in_frame_next;
                in_line_reg    <= in_line_next;
                line_count_reg <= line_count_next;
                last_width_reg <= last_width_next;
                line_total_reg <= line_total_next;
                byte_total_reg <= byte_total_next;
                drop_reg       <= drop_next;
            end
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (in_acc && res_valid)
        begin
            if (out_valid_reg && out_stall)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (in_acc && res_valid)
        begin
            if (out_valid_reg && out_stall)
                skid_reg <= res_next;
            else
                out_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_reg.result_kind;
    assign pixel        = out_reg.pixel;
    assign frame_width  = out_reg.frame_width;
    assign frame_height = out_reg.frame_height;
    assign frame_bytes  = out_reg.frame_bytes;
    assign overflow     = out_reg.overflow;

    `SCID_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid holds a transaction while the output register is empty")
    `SCID_ASSERT_NEXT(a_marker_empties_window, clk, rst_n, in_acc && is_marker,
        fill_reg == 2'd0, "window not emptied after a marker")
    `SCID_ASSERT_NEXT(a_summary_closes_frame, clk, rst_n,
        in_acc && res_valid && (res_next.result_kind == scid_pkg::KIND_SUMMARY),
        !in_frame_reg && !in_line_reg, "frame still open after its summary")

endmodule

// ----- verif/sync_code_image_deframer_checker.sv -----
// Checker for the sync code deframer: predicts results from accepted bytes and compares them
module sync_code_image_deframer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  byte_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        result_kind,
    input  logic [7:0]  pixel,
    input  logic [7:0]  frame_width,
    input  logic [7:0]  frame_height,
    input  logic [15:0] frame_bytes,
    input  logic        overflow,
    output int          fail_count,
    output int          pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0]       byte_limit;
    logic [7:0]        window [3];
    logic [1:0]        fill;
    logic              frame_open;
    logic              line_open;
    logic [7:0]        line_count;
    logic [7:0]        width_last;
    logic [7:0]        lines_seen;
    logic [15:0]       bytes_passed;
    logic              dropped;
    scid_pkg::result_t expected_results [$];
    scid_pkg::result_t want;

    function void push_result(input logic kind, input logic [7:0] px);
        scid_pkg::result_t r;
        r.result_kind  = kind;
        r.pixel        = px;
        r.frame_width  = width_last;
        r.frame_height = lines_seen;
        r.frame_bytes  = bytes_passed;
        r.overflow     = dropped;
        expected_results.push_back(r);
    endfunction

    function void take_byte(input logic [7:0] b);
        if (fill == scid_pkg::WINDOW_FULL && window[0] == scid_pkg::SYNC_LEAD &&
            window[1] == 8'h00 && window[2] == 8'h00 &&
            (b == scid_pkg::CODE_SOF || b == scid_pkg::CODE_SOL ||
             b == scid_pkg::CODE_EOL || b == scid_pkg::CODE_EOF)) begin
            window = '{default: 8'h00};
            fill = 2'd0;
            case (b)
                scid_pkg::CODE_SOF:
                begin
                    frame_open   = 1'b1;
                    line_open    = 1'b0;
                    line_count   = 8'd0;
                    width_last   = 8'd0;
                    lines_seen   = 8'd0;
                    bytes_passed = 16'd0;
                    dropped      = 1'b0;
                end
                scid_pkg::CODE_SOL:
                begin
                    if (frame_open)
                    begin
                        line_open  = 1'b1;
                        line_count = 8'd0;
                    end
                end
                scid_pkg::CODE_EOL:
                begin
                    if (frame_open)
                    begin
                        width_last = line_count;
                        if (lines_seen != scid_pkg::COUNT_MAX)
                            lines_seen = lines_seen + 8'd1;
                        line_open = 1'b0;
                    end
                end
                default:
                begin
                    if (frame_open)
                    begin
                        push_result(scid_pkg::KIND_SUMMARY, 8'h00);
                        frame_open = 1'b0;
                        line_open  = 1'b0;
                    end
                end
            endcase
        end
        else if (fill == scid_pkg::WINDOW_FULL)
        begin
            if (frame_open && line_open)
            begin
                if (line_count != scid_pkg::COUNT_MAX)
                    line_count = line_count + 8'd1;
                if (bytes_passed < byte_limit)
                begin
                    bytes_passed = bytes_passed + 16'd1;
                    push_result(scid_pkg::KIND_PIXEL, window[0]);
                end
                else
                    dropped = 1'b1;
            end
            window[0] = window[1];
            window[1] = window[2];
            window[2] = b;
        end
        else
        begin
            window[fill] = b;
            fill = fill + 2'd1;
        end
    endfunction

    function void check_field(input string field, input int unsigned exp_val,
                              input int unsigned got_val);
        if (exp_val != got_val)
        begin
            $error("%s: expected %0d, got %0d", field, exp_val, got_val);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_limit   = scid_pkg::MAX_FRAME_BYTES_RESET;
            window       = '{default: 8'h00};
            fill         = 2'd0;
            frame_open   = 1'b0;
            line_open    = 1'b0;
            line_count   = 8'd0;
            width_last   = 8'd0;
            lines_seen   = 8'd0;
            bytes_passed = 16'd0;
            dropped      = 1'b0;
            fail_count   = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_write_en)
                byte_limit = cfg_write_data;
            if (in_valid && !in_stall)
                take_byte(byte_in);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d pixel %0d bytes %0d",
                           result_kind, pixel, frame_bytes);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_kind", want.result_kind, result_kind);
                    check_field("pixel", want.pixel, pixel);
                    check_field("frame_width", want.frame_width, frame_width);
                    check_field("frame_height", want.frame_height, frame_height);
                    check_field("frame_bytes", want.frame_bytes, frame_bytes);
                    check_field("overflow", want.overflow, overflow);
                end
            end
        end
        pending_results = expected_results.size();
    end

endmodule

// ----- verif/sync_code_image_deframer_top_test.sv -----
// Testbench top for the sync code deframer: clock, reset, byte stimulus, limit writes and verdict
module sync_code_image_deframer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        cfg_write_en   = 1'b0;
    logic [15:0] cfg_write_data = 16'd0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [7:0]  byte_in        = 8'd0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic        result_kind;
    logic [7:0]  pixel;
    logic [7:0]  frame_width;
    logic [7:0]  frame_height;
    logic [15:0] frame_bytes;
    logic        overflow;
    int          fail_count;
    int          pending_results;
    int          bytes_sent     = 0;
    int          idle_cycles    = 0;
    bit          quiet          = 1'b0;

    sync_code_image_deframer_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_in        (byte_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .pixel          (pixel),
        .frame_width    (frame_width),
        .frame_height   (frame_height),
        .frame_bytes    (frame_bytes),
        .overflow       (overflow)
    );

    sync_code_image_deframer_checker deframer_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .byte_in         (byte_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .pixel           (pixel),
        .frame_width     (frame_width),
        .frame_height    (frame_height),
        .frame_bytes     (frame_bytes),
        .overflow        (overflow),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 3))
            0: return scid_pkg::CODE_SOF;
            1: return scid_pkg::CODE_SOL;
            2: return scid_pkg::CODE_EOL;
            default: return scid_pkg::CODE_EOF;
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 4) != 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 2))
            0: return scid_pkg::SYNC_LEAD;
            1: return 8'h00;
            default: return pick_code();
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        bit taken;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        bytes_sent++;
    endtask

    task automatic send_marker(input logic [7:0] code);
        send_byte(scid_pkg::SYNC_LEAD);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(code);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: repeat ($urandom_range(1, 8)) send_byte(pick_byte());
            1: send_marker(pick_code());
            default:
            begin
                send_byte(scid_pkg::SYNC_LEAD);
                send_byte(8'h00);
            end
        endcase
    endtask

    task automatic send_frame(input int max_lines, input int max_len);
        send_marker(scid_pkg::CODE_SOF);
        repeat ($urandom_range(0, max_lines))
        begin
            if ($urandom_range(0, 9) != 0)
                send_marker(scid_pkg::CODE_SOL);
            repeat ($urandom_range(0, max_len)) send_byte(pick_byte());
            if ($urandom_range(0, 19) == 0)
                send_noise();
            if ($urandom_range(0, 9) != 0)
                send_marker(scid_pkg::CODE_EOL);
        end
        if ($urandom_range(0, 9) != 0)
            send_marker(scid_pkg::CODE_EOF);
    endtask

    task automatic run_phase(input int target, input int max_lines, input int max_len);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0)
                send_noise();
            else
                send_frame(max_lines, max_len);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // receiver: random stall bursts
    initial
    begin
        int hold;
        forever
        begin
            hold = pick_gap();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_marker(scid_pkg::CODE_SOL);
        send_marker(scid_pkg::CODE_SOF);
        send_marker(scid_pkg::CODE_SOL);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h11);
        send_marker(scid_pkg::CODE_EOL);
        send_marker(scid_pkg::CODE_EOF);
        run_phase(15, 3, 6);

        wait_idle();
        write_limit(16'd0);
        run_phase(10, 2, 6);

        wait_idle();
        write_limit(16'hFFFF);
        send_marker(scid_pkg::CODE_SOF);
        send_marker(scid_pkg::CODE_SOL);
        repeat (257) send_byte(pick_byte());
        send_marker(scid_pkg::CODE_EOL);
        send_marker(scid_pkg::CODE_EOF);
        run_phase(10, 3, 6);

        wait_idle();
        write_limit(16'($urandom_range(1, 40)));
        run_phase(25, 3, 8);

        wait_idle();
        write_limit(16'd1);
        send_marker(scid_pkg::CODE_SOF);
        repeat (256) send_marker(scid_pkg::CODE_EOL);
        send_marker(scid_pkg::CODE_SOL);
        repeat (3) send_byte(pick_byte());
        send_marker(scid_pkg::CODE_EOL);
        send_marker(scid_pkg::CODE_EOF);
        run_phase(10, 2, 6);

        wait_idle();
        write_limit(16'($urandom_range(0, 65535)));
        run_phase(15, 3, 6);

        wait_idle();
        write_limit(16'($urandom_range(2, 60)));
        run_phase(15, 3, 8);

        wait_idle();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
